// File: src/three_stacks_in_one_memory_top_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef THREE_STACKS_IN_ONE_MEMORY_TOP_DEFINES_SVH
`define THREE_STACKS_IN_ONE_MEMORY_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stack block check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack block check failed one cycle later");

`endif

// File: src/tsm_pkg.sv
`default_nettype none

package tsm_pkg;

  localparam int CMD_W    = 2;
  localparam int SEL_W    = 2;
  localparam int PORT_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_TOP  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WB
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/three_stacks_in_one_memory_top.sv
// Each item passes the accept, execute and write-back states, and its result is then
// registered for output; write back waits while the output register is still full.
// The controller serves one item at a time, and the read of the shared word store
// is registered. Configuration beats are taken in every cycle.
// Reset (rst_n low, synchronous) empties all stacks, sets the capacity to
// sixteen and clears the result channel; the word store itself is not cleared.
`default_nettype none

module three_stacks_in_one_memory_top #(
  parameter int MAX_DEPTH  = 16,
  parameter int NUM_STACKS = 3,
  parameter int WORD_BITS  = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [tsm_pkg::CMD_W-1:0]        in_command,
  input  wire logic [tsm_pkg::SEL_W-1:0]        in_stack_select,
  input  wire logic signed [tsm_pkg::PORT_W-1:0] in_push_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [tsm_pkg::PORT_W-1:0]     out_read_value,
  output logic [tsm_pkg::STATUS_W-1:0]          out_status,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tsm_pkg::CFG_W-1:0]        cfg_data
);
  import tsm_pkg::*;

  ctrl_cmd_t         ctrl_cmd;
  dp_status_t        dp_status;
  logic [PORT_W-1:0] read_value;

  assign cfg_ready = 1'b1;

  tsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dp_status (dp_status),
    .ctrl_cmd  (ctrl_cmd)
  );

  tsm_datapath #(
    .MAX_DEPTH  (MAX_DEPTH),
    .NUM_STACKS (NUM_STACKS),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl_cmd        (ctrl_cmd),
    .dp_status       (dp_status),
    .in_command      (in_command),
    .in_stack_select (in_stack_select),
    .in_push_value   ($unsigned(in_push_value)),
    .cfg_we          (cfg_valid),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (read_value),
    .out_status      (out_status)
  );

  assign out_read_value = $signed(read_value);

endmodule

`default_nettype wire

// File: src/tsm_ctrl.sv
`default_nettype none

module tsm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  tsm_pkg::dp_status_t     dp_status,
  output tsm_pkg::ctrl_cmd_t      ctrl_cmd
);
  import tsm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt          = state_r;
    in_ready           = 1'b0;
    ctrl_cmd.load_item = 1'b0;
    ctrl_cmd.exec      = 1'b0;
    ctrl_cmd.load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl_cmd.load_item = 1'b1;
          state_nxt          = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl_cmd.exec = 1'b1;
        state_nxt     = S_WB;
      end
      S_WB: begin
        // The result waits here until the output register has room.
        if (dp_status.out_free) begin
          ctrl_cmd.load_out = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/tsm_datapath.sv
`default_nettype none

module tsm_datapath #(
  parameter int MAX_DEPTH  = 16,
  parameter int NUM_STACKS = 3,
  parameter int WORD_BITS  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  tsm_pkg::ctrl_cmd_t                 ctrl_cmd,
  output tsm_pkg::dp_status_t                dp_status,
  input  wire logic [tsm_pkg::CMD_W-1:0]     in_command,
  input  wire logic [tsm_pkg::SEL_W-1:0]     in_stack_select,
  input  wire logic [tsm_pkg::PORT_W-1:0]    in_push_value,
  input  wire logic                          cfg_we,
  input  wire logic [tsm_pkg::CFG_W-1:0]     cfg_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [tsm_pkg::PORT_W-1:0]         out_read_value,
  output logic [tsm_pkg::STATUS_W-1:0]       out_status
);
  import tsm_pkg::*;

  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SLOT_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int SIDX_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int MEM_DEPTH = NUM_STACKS * MAX_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // Item registers.
  logic [CMD_W-1:0]  cmd_r;
  logic [SEL_W-1:0]  sel_r;
  logic [PORT_W-1:0] val_r;

  // Capacity register.
  logic [CFG_W-1:0] cap_r;
  logic [CFG_W-1:0] cap_nxt;

  // Fill counts, one per stack.
  logic [CNT_W-1:0] fill_r [NUM_STACKS];
  logic [CNT_W-1:0] cnt_nxt;
  logic             cnt_we;

  // Word store.
  logic [WORD_BITS-1:0] mem [MEM_DEPTH];
  logic [WORD_BITS-1:0] rdata_r;
  logic [ADDR_W-1:0]    mem_addr;
  logic                 mem_we;
  logic                 mem_re;

  // Result held between execution and the output register.
  status_t res_status_r;
  status_t res_status_nxt;
  logic    res_read_r;

  logic              out_valid_r;
  logic [PORT_W-1:0] out_value_r;
  status_t           out_status_r;

  logic [SIDX_W-1:0] idx;
  logic              sel_bad;
  logic [CNT_W-1:0]  cnt;
  logic              full;
  logic              empty;
  logic [SLOT_W-1:0] slot;

  always_ff @(posedge clk) begin
    if (ctrl_cmd.load_item) begin
      cmd_r <= in_command;
      sel_r <= in_stack_select;
      val_r <= in_push_value;
    end
  end

  // A capacity write above the per-stack depth saturates to that depth; one below the current capacity is ignored.
  always_comb begin
    if (CMP_W'(cfg_data) > CMP_W'(MAX_DEPTH)) begin
      cap_nxt = CFG_W'(MAX_DEPTH);
    end else begin
      cap_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      if (CMP_W'(CAP_RESET) > CMP_W'(MAX_DEPTH)) begin
        cap_r <= CFG_W'(MAX_DEPTH);
      end else begin
        cap_r <= CAP_RESET;
      end
    end else if (cfg_we && (cap_nxt >= cap_r)) begin
      cap_r <= cap_nxt;
    end
  end

  assign idx     = SIDX_W'(sel_r);
  assign sel_bad = ({2'b00, sel_r} >= 4'(NUM_STACKS));
  assign cnt     = sel_bad ? '0 : fill_r[idx];
  assign full    = (CMP_W'(cnt) >= CMP_W'(cap_r)) || (cnt == CNT_W'(MAX_DEPTH));
  assign empty   = (cnt == '0);

  always_comb begin
    res_status_nxt = ST_OK;
    cnt_nxt        = cnt;
    cnt_we         = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    slot           = SLOT_W'(cnt - CNT_W'(1));
    case (cmd_r)
      CMD_PUSH: begin
        slot = SLOT_W'(cnt);
        if (sel_bad || full) begin
          res_status_nxt = ST_FULL;
        end else begin
          mem_we  = ctrl_cmd.exec;
          cnt_nxt = cnt + CNT_W'(1);
          cnt_we  = ctrl_cmd.exec;
        end
      end
      CMD_POP, CMD_TOP: begin
        if (sel_bad || empty) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          mem_re = ctrl_cmd.exec;
          if (cmd_r == CMD_POP) begin
            cnt_nxt = cnt - CNT_W'(1);
            cnt_we  = ctrl_cmd.exec;
          end
        end
      end
      default: begin
        res_status_nxt = ST_OK;
      end
    endcase
  end

  assign mem_addr = ADDR_W'(idx) * ADDR_W'(MAX_DEPTH) + ADDR_W'(slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill_r[i] <= '0;
      end
    end else if (cnt_we) begin
      fill_r[idx] <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= WORD_BITS'(val_r);
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_read_r   <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl_cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.load_out) begin
      out_value_r  <= res_read_r ? PORT_W'(rdata_r) : '0;
      out_status_r <= res_status_r;
    end
  end

  assign dp_status.out_free = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_read_value     = out_value_r;
  assign out_status         = out_status_r;

endmodule

`default_nettype wire

// File: src/tsm_checker.sv
`default_nettype none

`include "three_stacks_in_one_memory_top_defines.svh"

module tsm_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [tsm_pkg::PORT_W-1:0]   out_read_value,
  input wire logic [tsm_pkg::STATUS_W-1:0]        out_status
);
  import tsm_pkg::*;

  // A beat left waiting on the result channel stays offered, unchanged.
  `TSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_status))

  // A refused command never returns a word.
  `TSM_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && (out_status != ST_OK), out_read_value == '0)

  // Only one item is in flight, so the input closes right after a beat.
  `TSM_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // Status codes beyond the three defined ones never appear.
  `TSM_ASSERT_SAME(a_status_code, clk, rst_n, out_valid, (out_status == ST_OK) || (out_status == ST_FULL) || (out_status == ST_EMPTY))

endmodule

bind three_stacks_in_one_memory_top tsm_checker u_tsm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_value (out_read_value),
  .out_status     (out_status)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsm_pkg::*;

  localparam int MAX_DEPTH  = 16;
  localparam int NUM_STACKS = 3;
  localparam int CLK_HALF   = 5;

  // Codes that the package leaves unnamed but the ports can carry.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam logic [SEL_W-1:0] SEL_NONE  = 2'd3;

  typedef struct packed {
    logic signed [PORT_W-1:0] read_value;
    status_t                  status;
  } stack_reply_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SEL_W-1:0]  sel;
    logic [PORT_W-1:0] word;
    logic              typed;
    logic [PORT_W-1:0] read_value;
    status_t           status;
  } directed_row_t;

  localparam int NUM_DIRECTED = 25;

  // Empty and out-of-range stacks and the spare command code first, then the sign extremes
  // on stack 0, then stacks 1 and 2 interleaved so that neighbouring regions are told apart.
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{CMD_POP,   2'd0,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{CMD_TOP,   2'd2,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{CMD_PUSH,  SEL_NONE, 32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_FULL},
    '{CMD_POP,   SEL_NONE, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{CMD_TOP,   SEL_NONE, 32'hffff_ffff, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{CMD_SPARE, 2'd0,     32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK},
    '{CMD_SPARE, SEL_NONE, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{CMD_PUSH,  2'd0,     32'h7fff_ffff, 1'b1, 32'h0000_0000, ST_OK},
    '{CMD_PUSH,  2'd0,     32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{CMD_TOP,   2'd0,     32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
    '{CMD_POP,   2'd0,     32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
    '{CMD_POP,   2'd0,     32'h0000_0000, 1'b1, 32'h7fff_ffff, ST_OK},
    '{CMD_POP,   2'd0,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{CMD_PUSH,  2'd1,     32'hffff_ffff, 1'b1, 32'h0000_0000, ST_OK},
    '{CMD_PUSH,  2'd2,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    '{CMD_PUSH,  2'd1,     32'h0000_0001, 1'b0, 32'h0000_0000, ST_OK},
    '{CMD_TOP,   2'd2,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{CMD_POP,   2'd1,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{CMD_TOP,   2'd1,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{CMD_POP,   2'd2,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{CMD_TOP,   2'd2,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
    '{CMD_PUSH,  2'd2,     32'ha5a5_a5a5, 1'b0, 32'h0000_0000, ST_OK},
    '{CMD_POP,   2'd1,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{CMD_POP,   2'd2,     32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    '{CMD_POP,   2'd1,     32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_command = '0;
  logic [SEL_W-1:0]         in_stack_select = '0;
  logic signed [PORT_W-1:0] in_push_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [PORT_W-1:0] out_read_value;
  logic [STATUS_W-1:0]      out_status;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_data = '0;

  bit idling_on = 1'b1;

  // Shadow copy of the block's state.
  int unsigned       shadow_capacity;
  int unsigned       shadow_fill [NUM_STACKS];
  logic [PORT_W-1:0] shadow_words [NUM_STACKS*MAX_DEPTH];

  stack_reply_t awaited_replies [$];

  int mismatches;
  int replies_checked;
  int refused_full;
  int refused_empty;
  int capacity_writes;
  int stall_left;

  three_stacks_in_one_memory_top #(
    .MAX_DEPTH  (MAX_DEPTH),
    .NUM_STACKS (NUM_STACKS),
    .WORD_BITS  (PORT_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_stack_select (in_stack_select),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  task automatic apply_stack_op(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                                input logic [PORT_W-1:0] word, output stack_reply_t reply);
    int unsigned depth;
    reply.read_value = '0;
    reply.status     = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (sel >= NUM_STACKS) begin
          reply.status = ST_FULL;
        end else begin
          depth = shadow_fill[sel];
          if (depth >= shadow_capacity || depth >= MAX_DEPTH) begin
            reply.status = ST_FULL;
          end else begin
            shadow_words[sel*MAX_DEPTH + depth] = word;
            shadow_fill[sel] = depth + 1;
          end
        end
      end
      CMD_POP, CMD_TOP: begin
        if (sel >= NUM_STACKS || shadow_fill[sel] == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          depth = shadow_fill[sel];
          reply.read_value = shadow_words[sel*MAX_DEPTH + depth - 1];
          if (cmd == CMD_POP) begin
            shadow_fill[sel] = depth - 1;
          end
        end
      end
      default: ;
    endcase
    if (reply.status == ST_FULL) refused_full++;
    if (reply.status == ST_EMPTY) refused_empty++;
  endtask

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                           input logic [PORT_W-1:0] word, input logic typed,
                           input stack_reply_t typed_reply);
    stack_reply_t reply;
    int gap;
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_stack_select <= sel;
    in_push_value   <= word;
    do @(posedge clk); while (!in_ready);
    apply_stack_op(cmd, sel, word, reply);
    awaited_replies.push_back(typed ? typed_reply : reply);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [PORT_W-1:0] pick_word();
    logic [PORT_W-1:0] word;
    case ($urandom_range(0, 11))
      0:       word = 32'h7fff_ffff;
      1:       word = 32'h8000_0000;
      2:       word = 32'hffff_ffff;
      3:       word = 32'h0000_0000;
      default: word = $urandom;
    endcase
    return word;
  endfunction

  task automatic send_random(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel);
    send_item(cmd, sel, pick_word(), 1'b0, '0);
  endtask

  // Weighted commands on valid stacks, with a little noise: the spare command
  // code and the out-of-range stack number.
  task automatic random_phase(input int count, input int push_pct, input int pop_pct);
    int r;
    logic [CMD_W-1:0] cmd;
    logic [SEL_W-1:0] sel;
    for (int i = 0; i < count; i++) begin
      r   = $urandom_range(0, 99);
      sel = SEL_W'($urandom_range(0, NUM_STACKS - 1));
      if (r < 3) begin
        cmd = CMD_SPARE;
        sel = SEL_W'($urandom_range(0, 3));
      end else if (r < 6) begin
        cmd = CMD_W'($urandom_range(0, 2));
        sel = SEL_NONE;
      end else if (r < 6 + push_pct) begin
        cmd = CMD_PUSH;
      end else if (r < 6 + push_pct + pop_pct) begin
        cmd = CMD_POP;
      end else begin
        cmd = CMD_TOP;
      end
      send_random(cmd, sel);
    end
  endtask

  // Repeatedly fill a randomly chosen stack with a run of pushes, sometimes past its
  // capacity, then drain it one entry beyond empty with tops sprinkled in.
  task automatic sequence_phase(input int count);
    int issued;
    int run;
    logic [SEL_W-1:0] sel;
    issued = 0;
    while (issued < count) begin
      sel = SEL_W'($urandom_range(0, NUM_STACKS - 1));
      run = $urandom_range(1, MAX_DEPTH + 2);
      for (int i = 0; i < run; i++) begin
        send_random(CMD_PUSH, sel);
      end
      for (int i = 0; i <= run; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          send_random(CMD_TOP, sel);
          issued++;
        end
        send_random(CMD_POP, sel);
      end
      issued += 2*run + 1;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    int unsigned wanted;
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // Values beyond the depth saturate, and a value below the current capacity never takes effect.
    wanted = (value > MAX_DEPTH) ? MAX_DEPTH : value;
    if (wanted >= shadow_capacity) shadow_capacity = wanted;
    capacity_writes++;
  endtask

  // Result side: random stall bursts, and every beat compared with the
  // oldest outstanding prediction.
  always @(posedge clk) begin
    stack_reply_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: read_value %h status %0d",
                   $realtime, out_read_value, out_status);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          replies_checked++;
          if (out_read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $realtime, want.read_value, out_read_value);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $realtime, want.status, out_status);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= (stall_left == 1);
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(1, 8);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    stack_reply_t typed_reply;
    shadow_capacity = CAP_RESET;
    foreach (shadow_fill[i]) shadow_fill[i] = 0;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    mismatches      = 0;
    replies_checked = 0;
    refused_full    = 0;
    refused_empty   = 0;
    capacity_writes = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_capacity(5'd1);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      typed_reply.read_value = DIRECTED_ROWS[i].read_value;
      typed_reply.status     = DIRECTED_ROWS[i].status;
      send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].sel, DIRECTED_ROWS[i].word,
                DIRECTED_ROWS[i].typed, typed_reply);
    end
    drain_results();

    write_capacity(5'd31);
    random_phase(400, 64, 18);
    drain_results();

    write_capacity(5'd0);
    random_phase(400, 20, 58);
    drain_results();

    write_capacity(5'd16);
    sequence_phase(450);
    drain_results();

    write_capacity(5'd8);
    random_phase(300, 42, 38);
    drain_results();

    // The last stretch runs with both sides at full rate.
    write_capacity(5'd20);
    idling_on <= 1'b0;
    random_phase(300, 46, 36);
    drain_results();
    repeat (8) @(posedge clk);

    $display("Checked %0d results: %0d refused as full, %0d refused as empty.",
             replies_checked, refused_full, refused_empty);
    $display("Capacity register written %0d times, effective capacity %0d.",
             capacity_writes, shadow_capacity);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", awaited_replies.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
